### rtl/core/assert_macros.svh
// Assertion macros shared by the substring search RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, suspended while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// Next-cycle implication, suspended while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/core/sfms_pkg.sv
// Package for the substring first-match search: widths, register indexes,
// result and cell control types. No dependencies.
`default_nettype none

package sfms_pkg;

   localparam int PATTERN_MAX_DEFAULT = 32;
   localparam int INDEX_BITS_DEFAULT  = 16;

   localparam int TEXT_BYTE_W    = 8;
   localparam int MATCH_START_W  = 16;
   localparam int LENGTH_W       = 6;
   localparam int CSR_DATA_W     = 64;
   localparam int CSR_INDEX_W    = 3;
   localparam int PATTERN_REGS   = 4;
   localparam int BYTES_PER_REG  = CSR_DATA_W / TEXT_BYTE_W;

   // Register map
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_0_7   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_8_15  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_16_23 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_24_31 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd4;

   typedef struct packed {
      logic step;    // advance the partial-match bit
      logic clear;   // drop the bit at the end of a text
   } sfms_cell_ctrl_type;

   typedef struct packed {
      logic                     found;
      logic [MATCH_START_W-1:0] match_start;
      logic                     index_overflow;
   } sfms_result_type;

endpackage

`default_nettype wire

### rtl/core/sfms_channels.sv
// Valid/ready channel interfaces for text bytes in and search results out.
// Depends on sfms_pkg.
`default_nettype none

interface sfms_req_if;
   import sfms_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [TEXT_BYTE_W-1:0] text_byte;
   logic                   text_end;

   modport source (output valid, output text_byte, output text_end, input ready);
   modport sink   (input valid, input text_byte, input text_end, output ready);
endinterface

interface sfms_rsp_if;
   import sfms_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     found;
   logic [MATCH_START_W-1:0] match_start;
   logic                     index_overflow;

   modport source (output valid, output found, output match_start,
                   output index_overflow, input ready);
   modport sink   (input valid, input found, input match_start,
                   input index_overflow, output ready);
endinterface

`default_nettype wire

### rtl/core/sfms_cell.sv
// One cell of the shift-and chain: holds one partial-match bit and compares
// the text byte against its pattern byte. Depends on sfms_pkg.
`default_nettype none

module sfms_cell (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire sfms_pkg::sfms_cell_ctrl_type    ctrl,
   input  wire logic [sfms_pkg::TEXT_BYTE_W-1:0] text_byte,
   input  wire logic [sfms_pkg::TEXT_BYTE_W-1:0] pattern_byte,
   input  wire logic                            chain_in,
   output logic                                 hit_in,
   output logic                                 state_ff
);
   import sfms_pkg::*;

   logic state_in;

   // Prefix extends by one byte when the neighbour held the shorter prefix.
   assign hit_in = chain_in & (text_byte == pattern_byte);

   always_comb begin
      state_in = state_ff;
      if (ctrl.clear) begin
         state_in = 1'b0;
      end else if (ctrl.step) begin
         state_in = hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/substring_first_match_search.sv
// Top level of the substring first-match search: config registers, cell chain,
// position counter and result skid. Depends on sfms_pkg, sfms_channels,
// sfms_cell and assert_macros.svh.
//
//   channel  | dir | ports      | payload
//   ---------+-----+------------+-----------------------------------------
//   request  | in  | req_chan.* | text_byte[7:0], text_end
//   response | out | rsp_chan.* | found, match_start[15:0], index_overflow
//   config   | in  | csr_*      | csr_index[2:0], csr_wr_data[63:0]
//
// One text byte is taken per cycle while req_chan.ready is high; every cell of
// the chain updates its bit in the cycle the byte transfers, so the rate is one
// byte per clock while ready holds. Each result is registered onto rsp_chan.
// A two-entry output (register plus skid) lets bytes keep flowing while a
// result waits; req_chan.ready drops only when both entries are full.
// Reset is synchronous and clears pattern, length, chain, position and flags.
`default_nettype none

module substring_first_match_search #(
   parameter int PATTERN_MAX = sfms_pkg::PATTERN_MAX_DEFAULT,
   parameter int INDEX_BITS  = sfms_pkg::INDEX_BITS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   sfms_req_if.sink                              req_chan,
   sfms_rsp_if.source                            rsp_chan,
   input  wire logic                             csr_wr_en,
   input  wire logic [sfms_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [sfms_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import sfms_pkg::*;

`include "assert_macros.svh"

   localparam int PM_IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int POS_W    = INDEX_BITS + 1;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [CSR_DATA_W-1:0] pattern_ff [PATTERN_REGS];
   logic [CSR_DATA_W-1:0] pattern_in [PATTERN_REGS];
   logic [LENGTH_W-1:0]   length_ff;
   logic [LENGTH_W-1:0]   length_in;

   always_comb begin
      pattern_in = pattern_ff;
      length_in  = length_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_PATTERN_0_7:    pattern_in[0] = csr_wr_data;
            REG_PATTERN_8_15:   pattern_in[1] = csr_wr_data;
            REG_PATTERN_16_23:  pattern_in[2] = csr_wr_data;
            REG_PATTERN_24_31:  pattern_in[3] = csr_wr_data;
            REG_PATTERN_LENGTH: length_in = csr_wr_data[LENGTH_W-1:0];
            default: begin
               // unmapped index: drop the write
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PATTERN_REGS; i++) begin
            pattern_ff[i] <= '0;
         end
         length_ff <= '0;
      end else begin
         pattern_ff <= pattern_in;
         length_ff  <= length_in;
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   logic skid_valid_ff;
   logic req_fire;
   logic reported_ff;
   logic reported_in;
   logic active;
   logic text_last;

   assign req_chan.ready = ~skid_valid_ff;
   assign req_fire       = req_chan.valid & req_chan.ready;
   assign text_last      = req_chan.text_end;
   // Once the first match is reported, ignore bytes until the text ends.
   assign active         = req_fire & ~reported_ff;

   sfms_cell_ctrl_type cell_ctrl;
   assign cell_ctrl.step  = active;
   assign cell_ctrl.clear = req_fire & text_last;

   // ---------------------------------------------------------------------
   // Shift-and chain: cell k holds "last k+1 bytes equal pattern 0..k"
   // ---------------------------------------------------------------------
   logic [PATTERN_MAX-1:0] hit_vec;
   logic [PATTERN_MAX-1:0] state_vec;

   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
      logic chain_bit;
      if (k == 0) begin : g_head
         assign chain_bit = 1'b1;
      end else begin : g_link
         assign chain_bit = state_vec[k-1];
      end

      sfms_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (cell_ctrl),
         .text_byte    (req_chan.text_byte),
         .pattern_byte (pattern_ff[k / BYTES_PER_REG]
                                  [(k % BYTES_PER_REG) * TEXT_BYTE_W +: TEXT_BYTE_W]),
         .chain_in     (chain_bit),
         .hit_in       (hit_vec[k]),
         .state_ff     (state_vec[k])
      );
   end

   // ---------------------------------------------------------------------
   // Match detection and start index
   // ---------------------------------------------------------------------
   logic [LENGTH_W-1:0] len_m1;
   logic [PM_IDX_W-1:0] len_sel;
   logic                len_ok;
   logic                match;
   logic                new_result;
   logic [POS_W-1:0]    pos_ff;
   logic [POS_W-1:0]    pos_in;
   logic [POS_W-1:0]    len_ext;
   logic [POS_W-1:0]    start_raw;
   logic                start_ovf;
   logic [INDEX_BITS-1:0]               start_idx;
   logic [INDEX_BITS+MATCH_START_W-1:0] start_wide;
   sfms_result_type     result_new;

   assign len_m1  = length_ff - LENGTH_W'(1);
   assign len_sel = len_m1[PM_IDX_W-1:0];
   // A zero length, or one beyond the chain, never matches.
   assign len_ok  = (length_ff != '0) && (length_ff <= LENGTH_W'(PATTERN_MAX));
   assign match   = active & len_ok & hit_vec[len_sel];
   assign new_result = match | (active & text_last);

   assign len_ext   = POS_W'(len_m1);
   assign start_raw = (pos_ff >= len_ext) ? (pos_ff - len_ext) : '0;
   // Saturate at the top of the index range and flag it.
   assign start_ovf = start_raw[INDEX_BITS];
   assign start_idx = start_ovf ? '1 : start_raw[INDEX_BITS-1:0];
   assign start_wide = {{MATCH_START_W{1'b0}}, start_idx};

   always_comb begin
      result_new.found          = match;
      result_new.match_start    = match ? start_wide[MATCH_START_W-1:0] : '0;
      result_new.index_overflow = match & start_ovf;
   end

   always_comb begin
      pos_in      = pos_ff;
      reported_in = reported_ff;
      if (req_fire && text_last) begin
         pos_in      = '0;
         reported_in = 1'b0;
      end else begin
         if (active && (pos_ff != '1)) begin
            pos_in = pos_ff + POS_W'(1);
         end
         if (match) begin
            reported_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         reported_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         reported_ff <= reported_in;
      end
   end

   // ---------------------------------------------------------------------
   // Output register and skid entry
   // ---------------------------------------------------------------------
   logic            out_valid_ff;
   logic            out_valid_in;
   logic            skid_valid_in;
   logic            out_free;
   sfms_result_type out_ff;
   sfms_result_type out_in;
   sfms_result_type skid_ff;
   sfms_result_type skid_in;

   assign out_free = ~out_valid_ff | rsp_chan.ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            // Advance the parked result; no new one can arrive this cycle.
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = result_new;
            out_valid_in = new_result;
         end
      end else if (new_result) begin
         // Hold the new result aside while the consumer stalls.
         skid_in       = result_new;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.found          = out_ff.found;
   assign rsp_chan.match_start    = out_ff.match_start;
   assign rsp_chan.index_overflow = out_ff.index_overflow;

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   `ASSERT_IMPLIES(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `ASSERT_NEXT(a_stall_parks_result, clock, reset, out_valid_ff && !rsp_chan.ready && new_result, skid_valid_ff)
   `ASSERT_NEXT(a_end_clears_state, clock, reset, req_fire && text_last, (pos_ff == '0) && !reported_ff && (state_vec == '0))
   `ASSERT_NEXT(a_chain_frozen, clock, reset, reported_ff && !(req_fire && text_last), $stable(state_vec) && $stable(pos_ff))
   `ASSERT_NEXT(a_match_sets_report, clock, reset, match && !text_last, reported_ff)

endmodule

`default_nettype wire

### test/tb.sv
// Self-checking bench for substring_first_match_search: streams texts one byte per transfer
// and checks every search result against a shift-and predictor kept in this module.
// Depends on sfms_pkg, sfms_channels and the RTL of the search block.

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sfms_pkg::*;

   localparam int PATTERN_LIMIT = PATTERN_MAX_DEFAULT;
   localparam int INDEX_MAX     = (1 << MATCH_START_W) - 1;
   localparam int RANDOM_ITEMS  = 1800;
   localparam int SETTLE_CYCLES = 4;     // settle time once the bench is idle
   localparam int HOLD_CYCLES   = 80;    // long receiver hold-off
   localparam int DRAIN_CYCLES  = 500;

   typedef struct packed {
      logic [TEXT_BYTE_W-1:0] text_byte;
      logic                   text_end;
   } text_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wr_data;

   sfms_req_if text_chan ();
   sfms_rsp_if result_chan ();

   substring_first_match_search i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (text_chan),
      .rsp_chan    (result_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #6 clock = ~clock;

   // Bytes waiting to be offered, and search results still owed by the block.
   text_beat_type   pending_text[$];
   sfms_result_type expected_results[$];
   int              error_count = 0;

   // Mirror of the pattern registers and of the per-text search state.
   logic [CSR_DATA_W-1:0]    pattern_mirror [PATTERN_REGS];
   logic [LENGTH_W-1:0]      length_mirror;
   logic [PATTERN_LIMIT-1:0] partial_bits;
   logic [MATCH_START_W:0]   text_pos;
   logic                     report_sent;

   // Stimulus scratch: the pattern of the current phase and its byte alphabet.
   logic [TEXT_BYTE_W-1:0] phase_pattern [PATTERN_LIMIT];
   logic [TEXT_BYTE_W-1:0] alphabet [4];
   int                     random_items = 0;

   // Sender burst shaping and receiver stall shaping.
   int         burst_left;
   int         gap_left;
   logic [7:0] stall_pattern;
   int         pattern_age;
   int         hold_left;
   logic       pressure_req = 1'b0;

   // Hold every input at a known value from time zero.
   initial begin
      text_chan.valid      = 1'b0;
      text_chan.text_byte  = '0;
      text_chan.text_end   = 1'b0;
      result_chan.ready    = 1'b0;
      csr_wr_en            = 1'b0;
      csr_index            = '0;
      csr_wr_data          = '0;
   end

   // Advance the search by one accepted byte and record the result it owes, if any.
   function automatic void advance_search(input logic [TEXT_BYTE_W-1:0] value,
                                          input logic is_last);
      logic [PATTERN_LIMIT-1:0] hits;
      logic [MATCH_START_W:0]   pos;
      int unsigned              start;
      sfms_result_type          outcome;
      hits = '0;
      if (!report_sent) begin
         for (int k = 0; k < PATTERN_LIMIT; k++)
            hits[k] = (pattern_mirror[k / BYTES_PER_REG][(k % BYTES_PER_REG) * 8 +: 8] == value);
         pos          = text_pos;
         partial_bits = ((partial_bits << 1) | PATTERN_LIMIT'(1)) & hits;
         // position sticks at its top value, so late starts stay saturated
         if (text_pos != '1)
            text_pos = text_pos + 1'b1;
         if (length_mirror >= 1 && length_mirror <= PATTERN_LIMIT &&
             partial_bits[length_mirror - 1]) begin
            start = (pos >= length_mirror - 1) ? pos - (length_mirror - 1) : 0;
            outcome.found          = 1'b1;
            outcome.index_overflow = (start > INDEX_MAX);
            outcome.match_start    = (start > INDEX_MAX) ? MATCH_START_W'(INDEX_MAX)
                                                         : MATCH_START_W'(start);
            expected_results.push_back(outcome);
            report_sent = 1'b1;
         end else if (is_last) begin
            outcome = '0;
            expected_results.push_back(outcome);
         end
      end
      if (is_last) begin
         partial_bits = '0;
         text_pos     = '0;
         report_sent  = 1'b0;
      end
   endfunction

   // Driver: offer queued bytes in bursts of random length with random gaps between them.
   always @(posedge clock) begin : drive_text
      text_beat_type next_beat;
      if (reset) begin
         text_chan.valid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else if (!text_chan.valid || text_chan.ready) begin
         // nothing on offer, or the offered byte transfers at this edge
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            text_chan.valid <= 1'b0;
         end else if (pending_text.size() == 0) begin
            text_chan.valid <= 1'b0;
         end else begin
            next_beat = pending_text.pop_front();
            text_chan.valid     <= 1'b1;
            text_chan.text_byte <= next_beat.text_byte;
            text_chan.text_end  <= next_beat.text_end;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               // a third of the bursts run straight into the next one
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3);
            end else begin
               burst_left = burst_left - 1;
            end
         end
      end
   end

   // Receiver: rotate a stall pattern that is reloaded whenever its age counter wraps; a long
   // hold-off, when asked for, overrides it and is counted down here.
   always @(posedge clock) begin : drive_ready
      if (reset) begin
         result_chan.ready <= 1'b0;
         stall_pattern = 8'hFF;
         pattern_age   = 0;
         hold_left     = 0;
      end else begin
         if (pressure_req) begin
            hold_left    = HOLD_CYCLES;
            pressure_req = 1'b0;
         end
         if (pattern_age == 0) begin
            case ($urandom_range(0, 3))
               0:       stall_pattern = 8'hFF;
               1:       stall_pattern = 8'($urandom_range(0, 255));
               2:       stall_pattern = 8'hAA;
               default: stall_pattern = 8'($urandom_range(0, 255) | $urandom_range(0, 255));
            endcase
         end
         pattern_age = (pattern_age + 1) % 32;
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            result_chan.ready <= 1'b0;
         end else begin
            result_chan.ready <= stall_pattern[0];
         end
         stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
      end
   end

   // Monitor: predict on each byte transfer, check each result transfer against the oldest
   // expectation.
   always @(posedge clock) begin : watch_channels
      sfms_result_type want;
      if (!reset) begin
         if (text_chan.valid && text_chan.ready)
            advance_search(text_chan.text_byte, text_chan.text_end);
         if (result_chan.valid && result_chan.ready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result: found %0d, match_start %0d, index_overflow %0d",
                      result_chan.found, result_chan.match_start, result_chan.index_overflow);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (result_chan.found !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, result_chan.found);
                  error_count++;
               end
               if (result_chan.match_start !== want.match_start) begin
                  $error("match_start: expected %0d, got %0d",
                         want.match_start, result_chan.match_start);
                  error_count++;
               end
               if (result_chan.index_overflow !== want.index_overflow) begin
                  $error("index_overflow: expected %0d, got %0d",
                         want.index_overflow, result_chan.index_overflow);
                  error_count++;
               end
            end
         end
      end
   end

   function automatic void queue_byte(input logic [TEXT_BYTE_W-1:0] value, input logic is_last);
      pending_text.push_back(text_beat_type'{text_byte: value, text_end: is_last});
   endfunction

   // Write one register; the mirror follows at the edge where the block takes the write.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (index)
         REG_PATTERN_0_7, REG_PATTERN_8_15, REG_PATTERN_16_23, REG_PATTERN_24_31:
            pattern_mirror[index] = data;
         REG_PATTERN_LENGTH:
            length_mirror = data[LENGTH_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Write all four pattern words from phase_pattern, then the length with junk above it.
   task automatic load_pattern(input int length);
      logic [CSR_DATA_W-1:0] word;
      for (int r = 0; r < PATTERN_REGS; r++) begin
         for (int b = 0; b < BYTES_PER_REG; b++)
            word[b * 8 +: 8] = phase_pattern[r * BYTES_PER_REG + b];
         write_register(REG_PATTERN_0_7 + CSR_INDEX_W'(r), word);
      end
      word = {$urandom, $urandom};
      word[LENGTH_W-1:0] = LENGTH_W'(length);
      write_register(REG_PATTERN_LENGTH, word);
   endtask

   // Let every queued byte transfer and every owed result arrive, then settle.
   task automatic wait_idle();
      while (pending_text.size() != 0 || text_chan.valid || expected_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Queue one text over the phase alphabet, mostly with the pattern planted in it.
   task automatic queue_random_text(input logic terminate);
      logic [TEXT_BYTE_W-1:0] body[$];
      int  text_len;
      int  plant_at;
      int  len;
      bit  plant;
      len      = length_mirror;
      plant    = (len >= 1 && len <= PATTERN_LIMIT && $urandom_range(0, 9) < 6);
      text_len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
      if (plant)
         text_len += len;
      for (int i = 0; i < text_len; i++)
         body.push_back(($urandom_range(0, 4) != 0) ? alphabet[$urandom_range(0, 3)]
                                                    : TEXT_BYTE_W'($urandom_range(0, 255)));
      if (plant) begin
         plant_at = $urandom_range(0, text_len - len);
         for (int i = 0; i < len; i++)
            body[plant_at + i] = phase_pattern[i];
      end
      foreach (body[i])
         queue_byte(body[i], terminate && (i == text_len - 1));
      random_items += text_len;
   endtask

   initial begin : stimulus
      int drain_count;
      int phase_goal;
      int phase_start;
      int len;

      foreach (pattern_mirror[r])
         pattern_mirror[r] = '0;
      length_mirror = '0;
      partial_bits  = '0;
      text_pos      = '0;
      report_sent   = 1'b0;
      foreach (phase_pattern[k])
         phase_pattern[k] = TEXT_BYTE_W'($urandom_range(0, 255));

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---- directed part ----
      // zero length straight out of reset: never a match, the last byte says not-found
      queue_byte(8'h00, 1'b1);
      wait_idle();

      // one-byte pattern of all ones: hit at index 1, drop the rest of the text silently
      phase_pattern[0] = 8'hFF;
      load_pattern(1);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'hFF, 1'b1);
      wait_idle();

      // lengths above the pattern size never match
      load_pattern(40);
      queue_byte(8'hFF, 1'b1);
      wait_idle();
      load_pattern(63);
      queue_byte(8'hFF, 1'b1);
      wait_idle();

      // match completed by the last byte of the text
      phase_pattern[0] = 8'h00;
      phase_pattern[1] = 8'hFF;
      load_pattern(2);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b1);
      wait_idle();

      // change the pattern partway through a text: the partial match is kept
      phase_pattern[0] = 8'h12;
      phase_pattern[1] = 8'h34;
      phase_pattern[2] = 8'h56;
      load_pattern(3);
      queue_byte(8'h12, 1'b0);
      queue_byte(8'h34, 1'b0);
      wait_idle();
      phase_pattern[2] = 8'h78;
      load_pattern(3);
      queue_byte(8'h78, 1'b1);
      wait_idle();

      // writes to unmapped indexes must leave pattern and length alone
      for (int idx = REG_PATTERN_LENGTH + 1; idx < (1 << CSR_INDEX_W); idx++)
         write_register(CSR_INDEX_W'(idx), {$urandom, $urandom});
      queue_byte(8'h12, 1'b0);
      queue_byte(8'h34, 1'b0);
      queue_byte(8'h78, 1'b1);
      wait_idle();

      // ---- back-pressure: one-byte texts each owe a result; hold the receiver off long
      // enough for the output entries to fill and the byte channel to stall ----
      foreach (phase_pattern[k])
         phase_pattern[k] = TEXT_BYTE_W'($urandom_range(0, 255));
      load_pattern(1);
      for (int i = 0; i < 60; i++)
         queue_byte($urandom_range(0, 1) ? phase_pattern[0]
                                         : TEXT_BYTE_W'($urandom_range(0, 255)), 1'b1);
      pressure_req = 1'b1;
      wait_idle();

      // ---- random phases: fresh pattern and length each time ----
      while (random_items < RANDOM_ITEMS) begin
         foreach (alphabet[a])
            alphabet[a] = TEXT_BYTE_W'($urandom_range(0, 255));
         foreach (phase_pattern[k])
            phase_pattern[k] = ($urandom_range(0, 4) != 0) ? alphabet[$urandom_range(0, 3)]
                                                           : TEXT_BYTE_W'($urandom_range(0, 255));
         case ($urandom_range(0, 19))
            0:       len = 0;
            1, 2:    len = PATTERN_LIMIT;
            3:       len = $urandom_range(PATTERN_LIMIT + 1, (1 << LENGTH_W) - 1);
            4, 5:    len = $urandom_range(9, PATTERN_LIMIT - 1);
            default: len = $urandom_range(1, 8);
         endcase
         load_pattern(len);
         if ($urandom_range(0, 3) == 0)
            write_register(REG_PATTERN_LENGTH + CSR_INDEX_W'($urandom_range(1, 3)),
                           {$urandom, $urandom});
         phase_goal  = $urandom_range(60, 200);
         phase_start = random_items;
         while (random_items - phase_start < phase_goal)
            queue_random_text(1'b1);
         // now and then leave a text open across the next register change
         if ($urandom_range(0, 3) == 0)
            queue_random_text(1'b0);
         wait_idle();
      end
      // close any text still open
      queue_byte(TEXT_BYTE_W'($urandom_range(0, 255)), 1'b1);

      // ---- wind down ----
      while (pending_text.size() != 0 || text_chan.valid)
         @(negedge clock);
      drain_count = 0;
      while (expected_results.size() != 0 && drain_count < DRAIN_CYCLES) begin
         @(negedge clock);
         drain_count++;
      end
      repeat (SETTLE_CYCLES * 2) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d expected results never arrived", expected_results.size());
         error_count += expected_results.size();
      end
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Give up well beyond the slowest legal run.
   initial begin : run_limit
      #3_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
